FILE: rtl/core/qwsm_pkg.sv
`default_nettype none

package qwsm_pkg;

    // Defaults for the top-level parameters
    localparam int WHEELS_DEF    = 4;
    localparam int FRAC_BITS_DEF = 8;

    // Field widths
    localparam int COUNT_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int SPEED_W  = 34;
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = COUNT_W + SCALE_W;

    // Configuration port
    localparam int CFG_REGS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int APB_ADDR_W = CFG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [SCALE_W-1:0]  SPEED_SCALE  = 10'd1000;
    localparam logic [SPEED_W-1:0]  SPEED_MAX    = '1;

    // Item opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    // Variable nibble of a read address
    localparam logic [3:0] VAR_COUNT  = 4'h0;
    localparam logic [3:0] VAR_SPEED  = 4'h1;
    localparam logic [3:0] VAR_PERIOD = 4'hA;

    // Size codes of a read result
    localparam logic [2:0] SIZE_NONE = 3'd0;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] pin_levels;
        logic [7:0] reg_address;
    } in_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] read_data;
        logic               read_hit;
        logic [2:0]         read_size;
    } out_item_t;

    // Per-wheel record held in the state memory
    typedef struct packed {
        logic [COUNT_W-1:0]  edge_count;
        logic                prev_level;
        logic [PERIOD_W-1:0] elapsed_ms;
        logic [COUNT_W-1:0]  mark_count;
        logic [SPEED_W-1:0]  speed_value;
    } rec_t;

endpackage

`default_nettype wire

FILE: rtl/core/qwsm_regs.sv
`default_nettype none

module qwsm_regs #(
    parameter int WHEELS = qwsm_pkg::WHEELS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        psel,
    input  wire logic                                        penable,
    input  wire logic                                        pwrite,
    input  wire logic [qwsm_pkg::APB_ADDR_W-1:0]             paddr,
    input  wire logic [qwsm_pkg::APB_DATA_W-1:0]             pwdata,
    output logic      [qwsm_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                             pready,
    output logic [qwsm_pkg::CFG_REGS-1:0][qwsm_pkg::PERIOD_W-1:0] period_vec
);

    logic [qwsm_pkg::CFG_REGS-1:0][qwsm_pkg::PERIOD_W-1:0] period_reg;
    logic [qwsm_pkg::CFG_REGS-1:0][qwsm_pkg::PERIOD_W-1:0] period_next;
    logic [qwsm_pkg::CFG_IDX_W-1:0]                        reg_idx;
    logic                                                  wr_en;

    assign reg_idx = paddr[qwsm_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Period write; registers of absent wheels keep their reset value
    always_comb begin
        period_next = period_reg;
        if (wr_en && (int'(reg_idx) < WHEELS)) begin
            period_next[reg_idx] = pwdata[qwsm_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < qwsm_pkg::CFG_REGS; i++) begin
                period_reg[i] <= qwsm_pkg::PERIOD_RESET;
            end
        end else begin
            period_reg <= period_next;
        end
    end

    assign prdata     = qwsm_pkg::APB_DATA_W'(period_reg[reg_idx]);
    assign period_vec = period_reg;

endmodule

`default_nettype wire

FILE: rtl/core/qwsm_mem.sv
`default_nettype none

module qwsm_mem #(
    parameter int DEPTH = qwsm_pkg::WHEELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output qwsm_pkg::rec_t            rd_rec,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire qwsm_pkg::rec_t       wr_rec
);

    qwsm_pkg::rec_t   ram [DEPTH];
    qwsm_pkg::rec_t   rd_data_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_rec;
        end
    end

    // Read port, registered; data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    // Entry valid bits: an entry never written reads as all zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_rec = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/core/qwsm_div.sv
`default_nettype none

module qwsm_div #(
    parameter int NUM_W = qwsm_pkg::PROD_W + qwsm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [NUM_W-1:0]              num,
    input  wire logic [qwsm_pkg::PERIOD_W-1:0] den,
    output logic                               done,
    output logic [NUM_W-1:0]                   quo
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam int DW    = qwsm_pkg::PERIOD_W;

    logic [NUM_W-1:0] dvd_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;
    logic             last_step;

    // One restoring step: quotient bits shift in behind the dividend
    assign rem_sh    = {rem_reg, dvd_reg[NUM_W-1]};
    assign diff      = rem_sh - {1'b0, den_reg};
    assign ge        = rem_sh >= {1'b0, den_reg};
    assign last_step = cnt_reg == CNT_W'(NUM_W - 1);

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    // Step counter and completion strobe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

endmodule

`default_nettype wire

FILE: rtl/core/quad_wheel_speed_meter.sv
`default_nettype none

// Four-wheel encoder speed meter. Items arrive on the s_ channel: a pin sample
// counts level changes per wheel, a millisecond tick advances each wheel's
// measurement window and, at the end of a window, sets the speed to
// 1000*(edges in window)/period counts per second with FRAC_BITS fraction bits,
// and a read returns one result on the m_ channel (count, speed or period of a
// wheel, or a miss). Per-wheel state lives in a single-port-read state memory
// swept one wheel at a time; a closing window waits on the shared bit-serial
// divider. The periods must be written over the APB port only while no item is
// in flight; the block itself does not enforce this. A pending result does
// not stop the next item from being accepted, but a read then waits until the
// earlier result has been taken.

module quad_wheel_speed_meter #(
    parameter int WHEELS    = qwsm_pkg::WHEELS_DEF,
    parameter int FRAC_BITS = qwsm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire qwsm_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output qwsm_pkg::out_item_t                  m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qwsm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [qwsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [qwsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int NUM_W = qwsm_pkg::PROD_W + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_MOD  = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          wheel_reg, wheel_next;
    logic [1:0]                op_reg, op_next;
    logic [3:0]                pins_reg, pins_next;
    logic                      hit_reg, hit_next;
    logic [3:0]                var_reg, var_next;
    qwsm_pkg::rec_t            rec_reg;
    qwsm_pkg::out_item_t       out_reg;
    logic                      out_valid_reg, out_valid_next;

    logic [qwsm_pkg::CFG_REGS-1:0][qwsm_pkg::PERIOD_W-1:0] period_vec;

    qwsm_pkg::rec_t            cur;
    qwsm_pkg::rec_t            samp_rec, tick_rec, div_rec, wr_rec;
    qwsm_pkg::out_item_t       rd_item;
    logic                      mem_rd_en, mem_wr_en;
    logic                      rec_load, out_load, out_free, last_wheel;
    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_quo, div_num;
    logic [qwsm_pkg::PERIOD_W-1:0] period_w, den;
    logic [3:0]                idx4, wid, wid_m1;
    logic                      wid_ok, var_ok, lvl, wrap, meas;
    logic [qwsm_pkg::PERIOD_W-1:0] el1;
    logic [qwsm_pkg::COUNT_W-1:0]  delta;
    logic [qwsm_pkg::PROD_W-1:0]   prod;
    logic [63:0]               quo64;
    logic [qwsm_pkg::SPEED_W-1:0]  speed_sat;

    qwsm_regs #(
        .WHEELS (WHEELS)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .period_vec (period_vec)
    );

    qwsm_mem #(
        .DEPTH (WHEELS),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (wheel_reg),
        .rd_rec  (cur),
        .wr_en   (mem_wr_en),
        .wr_addr (wheel_reg),
        .wr_rec  (wr_rec)
    );

    qwsm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Wheel lookups: wheels beyond the fourth see level 0 and period 100
    assign idx4     = 4'(wheel_reg);
    assign period_w = (idx4 < 4'(qwsm_pkg::CFG_REGS))
                      ? period_vec[idx4[qwsm_pkg::CFG_IDX_W-1:0]]
                      : qwsm_pkg::PERIOD_RESET;
    assign lvl      = (idx4 < 4'd4) ? pins_reg[idx4[1:0]] : 1'b0;

    // Read address decode
    assign wid    = s_data.reg_address[3:0];
    assign wid_m1 = wid - 4'd1;
    assign wid_ok = (wid >= 4'd1) && (wid <= 4'(WHEELS));
    assign var_ok = (s_data.reg_address[7:4] == qwsm_pkg::VAR_COUNT)
                 || (s_data.reg_address[7:4] == qwsm_pkg::VAR_SPEED)
                 || (s_data.reg_address[7:4] == qwsm_pkg::VAR_PERIOD);

    // Sample update: count a level change
    always_comb begin
        samp_rec = cur;
        if (lvl != cur.prev_level) begin
            samp_rec.edge_count = cur.edge_count + 1'b1;
            samp_rec.prev_level = lvl;
        end
    end

    // Tick update; a closing window goes through the divider
    assign el1   = cur.elapsed_ms + 1'b1;
    assign wrap  = cur.mark_count > cur.edge_count;
    assign meas  = !wrap && (el1 >= period_w);
    assign delta = cur.edge_count - cur.mark_count;
    assign prod  = qwsm_pkg::PROD_W'(delta) * qwsm_pkg::PROD_W'(qwsm_pkg::SPEED_SCALE);
    assign div_num = NUM_W'(prod) << FRAC_BITS;
    assign den   = (period_w == '0) ? qwsm_pkg::PERIOD_W'(1) : period_w;

    always_comb begin
        tick_rec = cur;
        if (wrap) begin
            tick_rec.mark_count = cur.edge_count;
            tick_rec.elapsed_ms = '0;
        end else begin
            tick_rec.elapsed_ms = el1;
        end
    end

    // Window close: saturate the quotient into the speed field
    assign quo64     = 64'(div_quo);
    assign speed_sat = (quo64 > 64'(qwsm_pkg::SPEED_MAX))
                       ? qwsm_pkg::SPEED_MAX : quo64[qwsm_pkg::SPEED_W-1:0];

    always_comb begin
        div_rec             = rec_reg;
        div_rec.mark_count  = rec_reg.edge_count;
        div_rec.elapsed_ms  = '0;
        div_rec.speed_value = speed_sat;
    end

    // Read result
    always_comb begin
        rd_item.read_data = '0;
        rd_item.read_hit  = 1'b0;
        rd_item.read_size = qwsm_pkg::SIZE_NONE;
        if (hit_reg) begin
            rd_item.read_hit = 1'b1;
            unique case (var_reg)
                qwsm_pkg::VAR_COUNT: begin
                    rd_item.read_data = qwsm_pkg::SPEED_W'(cur.edge_count);
                    rd_item.read_size = qwsm_pkg::SIZE_HALF;
                end
                qwsm_pkg::VAR_SPEED: begin
                    rd_item.read_data = cur.speed_value;
                    rd_item.read_size = qwsm_pkg::SIZE_WORD;
                end
                default: begin
                    rd_item.read_data = qwsm_pkg::SPEED_W'(period_w);
                    rd_item.read_size = qwsm_pkg::SIZE_HALF;
                end
            endcase
        end
    end

    assign out_free   = !out_valid_reg || m_ready;
    assign last_wheel = wheel_reg == IDX_W'(WHEELS - 1);

    // Sequencer: read, modify and write back one wheel at a time
    always_comb begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        op_next    = op_reg;
        pins_next  = pins_reg;
        hit_next   = hit_reg;
        var_next   = var_reg;
        s_ready    = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        wr_rec     = samp_rec;
        rec_load   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next   = s_data.op;
                    pins_next = s_data.pin_levels;
                    hit_next  = wid_ok && var_ok;
                    var_next  = s_data.reg_address[7:4];
                    unique case (s_data.op)
                        qwsm_pkg::OP_SAMPLE, qwsm_pkg::OP_TICK: begin
                            wheel_next = '0;
                            state_next = S_RD;
                        end
                        qwsm_pkg::OP_READ: begin
                            wheel_next = wid_ok ? wid_m1[IDX_W-1:0] : '0;
                            state_next = S_RD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                mem_rd_en  = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                unique case (op_reg)
                    qwsm_pkg::OP_SAMPLE: begin
                        mem_wr_en  = 1'b1;
                        wr_rec     = samp_rec;
                        wheel_next = last_wheel ? '0 : wheel_reg + 1'b1;
                        state_next = last_wheel ? S_IDLE : S_RD;
                    end
                    qwsm_pkg::OP_TICK: begin
                        if (meas) begin
                            rec_load   = 1'b1;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end else begin
                            mem_wr_en  = 1'b1;
                            wr_rec     = tick_rec;
                            wheel_next = last_wheel ? '0 : wheel_reg + 1'b1;
                            state_next = last_wheel ? S_IDLE : S_RD;
                        end
                    end
                    qwsm_pkg::OP_READ: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    mem_wr_en  = 1'b1;
                    wr_rec     = div_rec;
                    wheel_next = last_wheel ? '0 : wheel_reg + 1'b1;
                    state_next = last_wheel ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wheel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        pins_reg <= pins_next;
        hit_reg  <= hit_next;
        var_reg  <= var_next;
        if (rec_load) begin
            rec_reg <= cur;
        end
        if (out_load) begin
            out_reg <= rd_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/qwsm_checker.sv
`default_nettype none

module qwsm_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire qwsm_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire qwsm_pkg::out_item_t m_data
);

    // A result stays offered until it is taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // Samples and ticks never raise a result on their own
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op != qwsm_pkg::OP_READ) && !m_valid
        |=> !m_valid)
        else $error("result raised by a sample or tick");

    // Every real item keeps the input busy straight after its transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op != qwsm_pkg::OP_RSVD) |=> !s_ready)
        else $error("input ready straight after an item transfer");

    // Hit flag and size agree
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.read_hit
                     ? (m_data.read_size == qwsm_pkg::SIZE_HALF
                        || m_data.read_size == qwsm_pkg::SIZE_WORD)
                     : (m_data.read_size == qwsm_pkg::SIZE_NONE
                        && m_data.read_data == '0)))
        else $error("read size does not match hit flag");

endmodule

bind quad_wheel_speed_meter qwsm_checker u_qwsm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: bench/qwsm_checker.sv
`default_nettype none

// Scoreboard for the wheel speed meter: mirrors the per-wheel counters,
// windows and periods, and checks every read result in order.
module qwsm_scoreboard (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire qwsm_pkg::in_item_t              s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire qwsm_pkg::out_item_t             m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [qwsm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [qwsm_pkg::APB_DATA_W-1:0] pwdata,
    output int                                   pending,
    output int                                   failures,
    output int                                   results_seen
);

    localparam int NUM_WHEELS = qwsm_pkg::WHEELS_DEF;
    localparam int PW         = qwsm_pkg::PERIOD_W;
    localparam int CW         = qwsm_pkg::COUNT_W;
    localparam int SW         = qwsm_pkg::SPEED_W;

    // Mirrored meter state, one entry per wheel
    logic [PW-1:0] period_cfg  [NUM_WHEELS];
    logic [CW-1:0] edges       [NUM_WHEELS];
    logic          level       [NUM_WHEELS];
    logic [PW-1:0] window_ms   [NUM_WHEELS];
    logic [CW-1:0] window_mark [NUM_WHEELS];
    logic [SW-1:0] speed       [NUM_WHEELS];

    // Read results still owed by the block, oldest first
    qwsm_pkg::out_item_t reads_due[$];

    // Edges per second over one window, 8 fraction bits, truncated
    function automatic logic [SW-1:0] window_speed(input logic [CW-1:0] delta,
                                                   input logic [PW-1:0] period);
        logic [63:0] divisor;
        logic [63:0] scaled;
        divisor = (period == '0) ? 64'd1 : 64'(period);
        scaled  = ((64'(delta) * 64'(qwsm_pkg::SPEED_SCALE)) << qwsm_pkg::FRAC_BITS_DEF)
                  / divisor;
        return (scaled > 64'(qwsm_pkg::SPEED_MAX)) ? qwsm_pkg::SPEED_MAX : scaled[SW-1:0];
    endfunction

    task automatic reset_meter();
        for (int w = 0; w < NUM_WHEELS; w++) begin
            period_cfg[w]  = qwsm_pkg::PERIOD_RESET;
            edges[w]       = '0;
            level[w]       = 1'b0;
            window_ms[w]   = '0;
            window_mark[w] = '0;
            speed[w]       = '0;
        end
    endtask

    // One millisecond for one wheel
    task automatic advance_ms(input int w);
        if (window_mark[w] > edges[w]) begin
            // counter wrapped inside the window: restart without measuring
            window_mark[w] = edges[w];
            window_ms[w]   = '0;
        end else begin
            window_ms[w] = window_ms[w] + 1'b1;
            if (window_ms[w] >= period_cfg[w]) begin
                speed[w]       = window_speed(edges[w] - window_mark[w], period_cfg[w]);
                window_mark[w] = edges[w];
                window_ms[w]   = '0;
            end
        end
    endtask

    task automatic take_item(input qwsm_pkg::in_item_t it);
        qwsm_pkg::out_item_t reply;
        logic [3:0]          var_sel;
        logic [3:0]          wheel_sel;
        int                  idx;
        reply     = '0;
        var_sel   = it.reg_address[7:4];
        wheel_sel = it.reg_address[3:0];
        case (it.op)
            qwsm_pkg::OP_SAMPLE: begin
                for (int w = 0; w < NUM_WHEELS; w++) begin
                    if (it.pin_levels[w] != level[w]) begin
                        edges[w] = edges[w] + 1'b1;
                        level[w] = it.pin_levels[w];
                    end
                end
            end
            qwsm_pkg::OP_TICK: begin
                for (int w = 0; w < NUM_WHEELS; w++)
                    advance_ms(w);
            end
            qwsm_pkg::OP_READ: begin
                if (wheel_sel >= 4'd1 && wheel_sel <= 4'(NUM_WHEELS)) begin
                    idx = int'(wheel_sel) - 1;
                    case (var_sel)
                        qwsm_pkg::VAR_COUNT: begin
                            reply = '{SW'(edges[idx]), 1'b1, qwsm_pkg::SIZE_HALF};
                        end
                        qwsm_pkg::VAR_SPEED: begin
                            reply = '{speed[idx], 1'b1, qwsm_pkg::SIZE_WORD};
                        end
                        qwsm_pkg::VAR_PERIOD: begin
                            reply = '{SW'(period_cfg[idx]), 1'b1, qwsm_pkg::SIZE_HALF};
                        end
                        default: ;
                    endcase
                end
                reads_due.push_back(reply);
            end
            default: ;  // reserved opcode is dropped
        endcase
    endtask

    task automatic log_fault(input string what, input qwsm_pkg::out_item_t want,
                             input qwsm_pkg::out_item_t got);
        failures++;
        if (failures <= 10)
            $display("%0t %s: expected %h hit %0d size %0d, got %h hit %0d size %0d",
                     $time, what, want.read_data, want.read_hit, want.read_size,
                     got.read_data, got.read_hit, got.read_size);
    endtask

    // Result transfers are checked before the input transfer of the same edge
    always @(posedge aclk) begin
        qwsm_pkg::out_item_t want;
        if (!aresetn) begin
            reset_meter();
            reads_due.delete();
            failures     = 0;
            results_seen = 0;
            pending     <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (reads_due.size() == 0) begin
                    log_fault("result with nothing outstanding", '0, m_data);
                end else begin
                    want = reads_due.pop_front();
                    if (m_data.read_data !== want.read_data ||
                        m_data.read_hit  !== want.read_hit  ||
                        m_data.read_size !== want.read_size)
                        log_fault("read result mismatch", want, m_data);
                end
            end
            if (s_valid && s_ready)
                take_item(s_data);
            if (psel && penable && pwrite && pready)
                period_cfg[paddr[qwsm_pkg::APB_ADDR_W-1:2]] = pwdata[PW-1:0];
            pending <= reads_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_quad_wheel_speed_meter.sv
`default_nettype none

module tb_quad_wheel_speed_meter;

    localparam int STALL_LIMIT = 5000;  // cycles without any transfer
    localparam int SETTLE      = 200;   // covers the longest tick
    localparam int AW          = qwsm_pkg::APB_ADDR_W;
    localparam int DW          = qwsm_pkg::APB_DATA_W;
    localparam int PW          = qwsm_pkg::PERIOD_W;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    qwsm_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    qwsm_pkg::out_item_t m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [AW-1:0]       paddr   = '0;
    logic [DW-1:0]       pwdata  = '0;
    logic [DW-1:0]       prdata;
    logic                pready;

    int         chk_pending;
    int         chk_failures;
    int         chk_results;
    logic       quiet     = 1'b0;   // no idling on either side
    logic [3:0] pin_state = '0;     // last levels sent in a sample
    int         op_count [4];
    int         settings  = 0;
    int         idle_cycles = 0;
    int         rx_hold   = 0;
    int         rx_draw;

    always #5 aclk = ~aclk;

    quad_wheel_speed_meter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qwsm_scoreboard i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (chk_pending),
        .failures     (chk_failures),
        .results_seen (chk_results)
    );

    // Result side: stall a random number of cycles per result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 2;
        end else if (m_valid && m_ready) begin
            rx_draw = quiet ? 0 : $urandom_range(0, 5);
            m_ready <= (rx_draw == 0);
            rx_hold <= rx_draw;
        end else if (m_valid && !m_ready) begin
            if (rx_hold <= 1)
                m_ready <= 1'b1;
            rx_hold <= rx_hold - 1;
        end
    end

    // Watchdog: no transfer of any kind for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Returns at the edge of the transfer; valid is only dropped ahead of a gap
    task automatic send_item(input logic [1:0] op, input logic [3:0] pins,
                             input logic [7:0] addr);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{op, pins, addr};
        do @(posedge aclk); while (!s_ready);
        op_count[op]++;
        if (op == qwsm_pkg::OP_SAMPLE)
            pin_state = pins;
    endtask

    // Let every read come back, then give a closing tick time to finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_periods(input logic [PW-1:0] p0, input logic [PW-1:0] p1,
                               input logic [PW-1:0] p2, input logic [PW-1:0] p3);
        logic [PW-1:0] vals [qwsm_pkg::CFG_REGS];
        vals[0] = p0;
        vals[1] = p1;
        vals[2] = p2;
        vals[3] = p3;
        wait_idle();
        // back-to-back APB writes, junk in the unused upper half
        for (int i = 0; i < qwsm_pkg::CFG_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= AW'(i * 4);
            pwdata  <= {16'($urandom), vals[i]};
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    task automatic run_random(input int count);
        logic [1:0] op;
        logic [7:0] addr;
        int         pick;
        for (int k = 0; k < count; k++) begin
            if (k % 35 == 0)
                quiet <= ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            addr = 8'($urandom);
            if (pick < 45) begin
                op = qwsm_pkg::OP_SAMPLE;
            end else if (pick < 75) begin
                op = qwsm_pkg::OP_TICK;
            end else if (pick < 97) begin
                op = qwsm_pkg::OP_READ;
                // mostly mapped registers, the rest any address
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 2))
                        0:       addr[7:4] = qwsm_pkg::VAR_COUNT;
                        1:       addr[7:4] = qwsm_pkg::VAR_SPEED;
                        default: addr[7:4] = qwsm_pkg::VAR_PERIOD;
                    endcase
                    addr[3:0] = 4'($urandom_range(1, qwsm_pkg::WHEELS_DEF));
                end
            end else begin
                op = qwsm_pkg::OP_RSVD;
            end
            send_item(op, 4'($urandom), addr);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, misses and the reserved opcode
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_PERIOD, 4'd1});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_PERIOD, 4'd2});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_PERIOD, 4'd3});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_PERIOD, 4'd4});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_COUNT, 4'd1});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_SPEED, 4'd4});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'h00);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'h05);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'h0F);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'h21);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'hB2);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'hF3);
        send_item(qwsm_pkg::OP_READ, 4'($urandom), 8'hFF);
        send_item(qwsm_pkg::OP_RSVD, 4'hF, {qwsm_pkg::VAR_PERIOD, 4'd1});
        // Level extremes and alternating patterns
        send_item(qwsm_pkg::OP_SAMPLE, 4'hF, 8'($urandom));
        send_item(qwsm_pkg::OP_SAMPLE, 4'h0, 8'($urandom));
        send_item(qwsm_pkg::OP_SAMPLE, 4'h5, 8'($urandom));
        send_item(qwsm_pkg::OP_SAMPLE, 4'hA, 8'($urandom));
        send_item(qwsm_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        for (int w = 1; w <= qwsm_pkg::WHEELS_DEF; w++)
            send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_COUNT, 4'(w)});

        // Shortest window: every tick closes a window on every wheel
        set_periods(16'd1, 16'd1, 16'd1, 16'd1);
        quiet <= 1'b1;
        send_item(qwsm_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        for (int k = 0; k < 20; k++)
            send_item(qwsm_pkg::OP_SAMPLE, ~pin_state, 8'($urandom));
        send_item(qwsm_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        for (int w = 1; w <= qwsm_pkg::WHEELS_DEF; w++)
            send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_SPEED, 4'(w)});
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_COUNT, 4'd2});
        send_item(qwsm_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        send_item(qwsm_pkg::OP_READ, 4'($urandom), {qwsm_pkg::VAR_SPEED, 4'd3});

        // Random traffic under several period settings
        set_periods(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
        run_random(120);
        set_periods(16'd0, 16'hFFFF, 16'd1, 16'd2);
        run_random(120);
        set_periods(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
        run_random(120);
        set_periods(16'hFFFF, 16'd0, 16'd3, qwsm_pkg::PERIOD_RESET);
        run_random(120);
        wait_idle();

        $display("Run covered %0d samples, %0d ticks, %0d reads and %0d reserved items",
                 op_count[qwsm_pkg::OP_SAMPLE], op_count[qwsm_pkg::OP_TICK],
                 op_count[qwsm_pkg::OP_READ], op_count[qwsm_pkg::OP_RSVD]);
        $display("over %0d period settings incl. zero and full-scale; %0d results checked",
                 settings, chk_results);
        if (chk_failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
